// File: rtl/cwq_pkg.sv
`default_nettype none
package cwq_pkg;

  localparam int unsigned MAX_CHUNKS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned TOT_W      = 12;
  localparam int unsigned OUT_W      = 40;

  localparam logic [TOT_W-1:0] ADDED_MAX    = 12'd4095;
  localparam logic [CNT_W-1:0] FINISHED_MAX = 9'd511;
  localparam logic [CNT_W-1:0] QUEUE_FULL   = 9'd256;

  localparam logic [1:0] KIND_BACK  = 2'd0;
  localparam logic [1:0] KIND_FRONT = 2'd1;
  localparam logic [1:0] KIND_TAKE  = 2'd2;
  localparam logic [1:0] KIND_MARK  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MARK, S_CHK, S_SCAN_RD, S_SCAN_CMP, S_SH, S_SH_WR,
    S_PUT, S_APPEND, S_POP_RD, S_POP, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_MARK, CMD_SCAN_RD, CMD_SCAN_CMP, CMD_SH_RD,
    CMD_SH_WR, CMD_PUT, CMD_APPEND, CMD_POP_RD, CMD_POP, CMD_RESULT
  } cmd_e;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_ok;
    logic       found;
    logic       scan_end;
    logic       p_lt_bl;
    logic       p_eq_bl;
    logic       q_empty;
    logic       q_full;
    logic       pop_ok;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/cwq_ctrl.sv
`default_nettype none
module cwq_ctrl import cwq_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire status_t st_i,
  output cmd_e         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        unique case (st_i.kind)
          KIND_TAKE: state_d = S_POP_RD;
          KIND_MARK: state_d = S_MARK;
          default:   state_d = S_CHK;
        endcase
      end
      S_MARK: state_d = S_OUT;
      S_CHK: begin
        state_d = st_i.idx_ok ? S_SCAN_RD : S_OUT;
      end
      S_SCAN_RD: begin
        if (st_i.found) begin
          // a back request never moves; a front one skips its own batch
          if (st_i.kind == KIND_BACK || st_i.p_lt_bl) state_d = S_OUT;
          else state_d = S_SH;
        end else if (st_i.scan_end) begin
          if (st_i.q_full) state_d = S_OUT;
          else if (st_i.kind == KIND_BACK) state_d = S_APPEND;
          else state_d = S_SH;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_d = S_SCAN_RD;
      S_SH: begin
        state_d = st_i.p_eq_bl ? S_PUT : S_SH_WR;
      end
      S_SH_WR:  state_d = S_SH;
      S_PUT:    state_d = S_OUT;
      S_APPEND: state_d = S_OUT;
      S_POP_RD: begin
        state_d = st_i.q_empty ? S_OUT : S_POP;
      end
      S_POP: begin
        state_d = st_i.pop_ok ? S_OUT : S_POP_RD;
      end
      S_OUT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LOAD;
      end
      S_MARK: cmd_o = CMD_MARK;
      S_SCAN_RD: begin
        if (!st_i.found && !st_i.scan_end) cmd_o = CMD_SCAN_RD;
      end
      S_SCAN_CMP: cmd_o = CMD_SCAN_CMP;
      S_SH: begin
        if (!st_i.p_eq_bl) cmd_o = CMD_SH_RD;
      end
      S_SH_WR:  cmd_o = CMD_SH_WR;
      S_PUT:    cmd_o = CMD_PUT;
      S_APPEND: cmd_o = CMD_APPEND;
      S_POP_RD: begin
        if (!st_i.q_empty) cmd_o = CMD_POP_RD;
      end
      S_POP: cmd_o = CMD_POP;
      S_OUT: begin
        if (st_i.out_free) cmd_o = CMD_RESULT;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cwq_dp.sv
`default_nettype none
module cwq_dp import cwq_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [CNT_W-1:0] cfg_wdata_i,
  input  wire  [15:0]      in_data_i,
  input  wire  [1:0]       in_user_i,
  input  wire  cmd_e       cmd_i,
  output status_t          st_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  logic [IDX_W-1:0] mem [MAX_CHUNKS];
  logic [IDX_W-1:0] rdata_q;

  logic [CNT_W-1:0]      chunk_count_q;
  logic [MAX_CHUNKS-1:0] done_q;
  logic [IDX_W-1:0]      head_q, idx_q, taken_q;
  logic [CNT_W-1:0]      ql_q, bl_q, p_q, fin_q;
  logic [TOT_W-1:0]      added_q;
  logic [1:0]            kind_q;
  logic                  bif_q, found_q, tvalid_q, placed_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_wdata, mem_raddr, done_addr;
  logic             done_bit, idx_ok;
  logic [CNT_W-1:0] ql_dec;
  logic             in_front;

  assign done_addr = (cmd_i == CMD_POP) ? rdata_q : idx_q;
  assign done_bit  = done_q[done_addr];
  assign idx_ok    = ({1'b0, idx_q} < chunk_count_q) && !done_bit;
  assign ql_dec    = ql_q - 9'd1;
  assign in_front  = (in_user_i == KIND_FRONT);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = idx_q;
    mem_waddr = head_q + p_q[IDX_W-1:0];
    unique case (cmd_i)
      CMD_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      CMD_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = head_q + bl_q[IDX_W-1:0];
      end
      CMD_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = head_q + ql_q[IDX_W-1:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd_i)
      CMD_SH_RD:  mem_raddr = head_q + p_q[IDX_W-1:0] - 8'd1;
      CMD_POP_RD: mem_raddr = head_q;
      default:    mem_raddr = head_q + p_q[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i == CMD_SCAN_RD || cmd_i == CMD_SH_RD || cmd_i == CMD_POP_RD) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_count_q <= 9'd1;
      done_q        <= '0;
      head_q        <= '0;
      idx_q         <= '0;
      taken_q       <= '0;
      ql_q          <= '0;
      bl_q          <= '0;
      p_q           <= '0;
      fin_q         <= '0;
      added_q       <= '0;
      kind_q        <= KIND_BACK;
      bif_q         <= 1'b0;
      found_q       <= 1'b0;
      tvalid_q      <= 1'b0;
      placed_q      <= 1'b0;
      out_valid_o   <= 1'b0;
      out_data_o    <= '0;
    end else begin
      if (cfg_we_i) chunk_count_q <= cfg_wdata_i;
      if (cmd_i == CMD_RESULT) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (cmd_i)
        CMD_LOAD: begin
          idx_q    <= in_data_i[7:0];
          kind_q   <= in_user_i;
          p_q      <= '0;
          found_q  <= 1'b0;
          taken_q  <= '0;
          tvalid_q <= 1'b0;
          placed_q <= 1'b0;
          // a new batch opens on request or when the side changes
          if ((in_user_i == KIND_BACK || in_front) &&
              (in_data_i[8] || in_front != bif_q)) begin
            bl_q  <= '0;
            bif_q <= in_front;
          end
        end
        CMD_MARK: begin
          if (idx_ok) begin
            done_q[idx_q] <= 1'b1;
            if (fin_q != FINISHED_MAX) fin_q <= fin_q + 9'd1;
          end
        end
        CMD_SCAN_CMP: begin
          if (rdata_q == idx_q) found_q <= 1'b1;
          else p_q <= p_q + 9'd1;
        end
        CMD_SH_WR: p_q <= p_q - 9'd1;
        CMD_PUT: begin
          bl_q     <= bl_q + 9'd1;
          placed_q <= 1'b1;
          if (!found_q) begin
            ql_q <= ql_q + 9'd1;
            if (added_q != ADDED_MAX) added_q <= added_q + 12'd1;
          end
        end
        CMD_APPEND: begin
          bl_q     <= bl_q + 9'd1;
          placed_q <= 1'b1;
          ql_q     <= ql_q + 9'd1;
          if (added_q != ADDED_MAX) added_q <= added_q + 12'd1;
        end
        CMD_POP: begin
          head_q <= head_q + 8'd1;
          ql_q   <= ql_dec;
          if (bif_q) begin
            if (bl_q != '0) bl_q <= bl_q - 9'd1;
          end else if (bl_q > ql_dec) begin
            bl_q <= ql_dec;
          end
          if (!done_bit) begin
            taken_q  <= rdata_q;
            tvalid_q <= 1'b1;
          end
        end
        CMD_RESULT: begin
          out_data_o <= {fin_q, added_q, ql_q, placed_q, tvalid_q, taken_q};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_o.kind     = kind_q;
    st_o.idx_ok   = idx_ok;
    st_o.found    = found_q;
    st_o.scan_end = (p_q == ql_q);
    st_o.p_lt_bl  = (p_q < bl_q);
    st_o.p_eq_bl  = (p_q == bl_q);
    st_o.q_empty  = (ql_q == '0);
    st_o.q_full   = (ql_q == QUEUE_FULL);
    st_o.pop_ok   = !done_bit;
    st_o.out_free = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

// File: rtl/chunk_work_queue_with_promotion.sv
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: chunk_index, batch_start; tuser: kind
// m_axis    out  tvalid/tready          tdata: taken_index .. done_total
// cfg       in   cfg_we_i               cfg_wdata_i: chunk_count
// one request at a time; a mark done steps through dispatch, mark and result, and a take pops
// entries from the head until it hands out a chunk that is not done or the queue runs empty
// an enqueue scans the queue one entry at a time (single memory read port), and a front
// enqueue shifts each entry that it moves with a read and then a write
// reset clears counters, done bitmap and queue length at once, no clearing pass
// a new request is taken while the previous result waits in the output register
`default_nettype none
module chunk_work_queue_with_promotion import cwq_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [CNT_W-1:0]  cfg_wdata_i,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [15:0]       s_axis_tdata,  // chunk_index, batch_start
  input  wire  [1:0]        s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  // taken_index, taken_valid, placed, pending_count, queued_total, done_total
  output logic [OUT_W-1:0]  m_axis_tdata
);

  status_t st;
  cmd_e    cmd;

  cwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cwq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: rtl/cwq_checker.sv
`default_nettype none
module cwq_checker import cwq_pkg::*; (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              m_axis_tvalid,
  input wire              m_axis_tready,
  input wire [OUT_W-1:0]  m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:10] <= 9'd256)
    else $error("pending count beyond depth");

  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("index without a take");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("take and enqueue flags both set");

endmodule

bind chunk_work_queue_with_promotion cwq_checker u_cwq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/sv/chunk_work_queue_with_promotion_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module chunk_work_queue_with_promotion_checker import cwq_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [CNT_W-1:0]  cfg_wdata_i,
  input  wire               s_axis_tvalid,
  input  wire               s_axis_tready,
  input  wire  [15:0]       s_axis_tdata,
  input  wire  [1:0]        s_axis_tuser,
  input  wire               m_axis_tvalid,
  input  wire               m_axis_tready,
  input  wire  [OUT_W-1:0]  m_axis_tdata,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic [CNT_W-1:0] done_total;
    logic [TOT_W-1:0] queued_total;
    logic [CNT_W-1:0] pending_count;
    logic             placed;
    logic             taken_valid;
    logic [IDX_W-1:0] taken_index;
  } outcome_t;

  logic [CNT_W-1:0] limit_q;
  logic [IDX_W-1:0] order_q [MAX_CHUNKS];
  int               order_len;
  bit               finished_q [MAX_CHUNKS];
  int               run_len;
  bit               run_front;
  int               added_cnt;
  int               finished_cnt;
  outcome_t         outcome_q [8];
  int               wr_ptr;
  int               rd_ptr;

  function automatic bit in_range(int idx);
    return idx < limit_q && idx < MAX_CHUNKS;
  endfunction

  function automatic int locate(int idx, int lo, int hi);
    for (int p = lo; p < hi; p++) if (order_q[p] == idx) return p;
    return hi;
  endfunction

  function automatic bit place_chunk(int idx, bit front, bit start);
    int lo, hi, pos;
    if (start || front != run_front) begin
      run_len = 0;
      run_front = front;
    end
    if (!in_range(idx) || finished_q[idx]) return 0;
    lo = front ? 0 : order_len - run_len;
    hi = front ? run_len : order_len;
    if (locate(idx, lo, hi) != hi) return 0;
    pos = locate(idx, 0, order_len);
    if (pos != order_len) begin
      if (!front) return 0;
      for (int p = pos; p > run_len; p--) order_q[p] = order_q[p-1];
      order_q[run_len] = idx[IDX_W-1:0];
    end else begin
      if (order_len >= MAX_CHUNKS) return 0;
      if (front) begin
        for (int p = order_len; p > run_len; p--) order_q[p] = order_q[p-1];
        order_q[run_len] = idx[IDX_W-1:0];
      end else begin
        order_q[order_len] = idx[IDX_W-1:0];
      end
      order_len++;
      if (added_cnt < ADDED_MAX) added_cnt++;
    end
    run_len++;
    return 1;
  endfunction

  function automatic outcome_t predict_request(logic [1:0] kind, int idx, bit start);
    outcome_t o;
    int head;
    o = '0;
    case (kind)
      KIND_BACK, KIND_FRONT: begin
        o.placed = place_chunk(idx, kind == KIND_FRONT, start);
      end
      KIND_TAKE: begin
        while (order_len > 0 && !o.taken_valid) begin
          head = order_q[0];
          for (int p = 0; p < order_len - 1; p++) order_q[p] = order_q[p+1];
          order_len--;
          if (run_front) begin
            if (run_len > 0) run_len--;
          end else if (run_len > order_len) begin
            run_len = order_len;
          end
          if (!finished_q[head]) begin
            o.taken_valid = 1;
            o.taken_index = head[IDX_W-1:0];
          end
        end
      end
      default: begin
        if (in_range(idx) && !finished_q[idx]) begin
          finished_q[idx] = 1;
          if (finished_cnt < FINISHED_MAX) finished_cnt++;
        end
      end
    endcase
    o.pending_count = order_len[CNT_W-1:0];
    o.queued_total = added_cnt[TOT_W-1:0];
    o.done_total = finished_cnt[CNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      limit_q = 1;
      order_len = 0;
      run_len = 0;
      run_front = 0;
      added_cnt = 0;
      finished_cnt = 0;
      foreach (finished_q[i]) finished_q[i] = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q[wr_ptr[2:0]] = predict_request(s_axis_tuser, int'(s_axis_tdata[7:0]),
                                                 s_axis_tdata[8]);
        wr_ptr++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (wr_ptr == rd_ptr) begin
          $display("%0t: result with none expected, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q[rd_ptr[2:0]];
          rd_ptr++;
          if (got.taken_index !== want.taken_index || got.taken_valid !== want.taken_valid ||
              got.placed !== want.placed || got.pending_count !== want.pending_count ||
              got.queued_total !== want.queued_total || got.done_total !== want.done_total) begin
            $display("%0t: mismatch expected idx=%0d v=%0d pl=%0d pend=%0d q=%0d d=%0d",
                     $time, want.taken_index, want.taken_valid, want.placed,
                     want.pending_count, want.queued_total, want.done_total);
            $display("%0t:            actual idx=%0d v=%0d pl=%0d pend=%0d q=%0d d=%0d",
                     $time, got.taken_index, got.taken_valid, got.placed,
                     got.pending_count, got.queued_total, got.done_total);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= wr_ptr - rd_ptr;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/chunk_work_queue_with_promotion_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module chunk_work_queue_with_promotion_tb;
  import cwq_pkg::*;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             cfg_we_i = 0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 0;
  wire              s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  wire              m_axis_tvalid;
  logic             m_axis_tready = 0;
  wire  [OUT_W-1:0] m_axis_tdata;
  int               fail_count;
  int               outstanding;
  bit               calm_stretch = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  chunk_work_queue_with_promotion dut (.*);

  chunk_work_queue_with_promotion_checker u_checker (.*);

  always @(posedge clk_i)
    m_axis_tready <= calm_stretch || ($urandom_range(99) >= 17);

  // the block takes no new request until the last one is done, so the gap after an accept costs nothing
  task automatic send_request(logic [1:0] kind, int idx, bit start);
    while (!calm_stretch && $urandom_range(99) < 17) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, start, idx[7:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (outstanding != 0 || s_axis_tvalid);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_chunk_count(int value);
    cfg_we_i <= 1;
    cfg_wdata_i <= value[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // mostly batches of enqueues with takes and marks between
  task automatic random_phase(int requests, int span);
    int r;
    bit front;
    for (int i = 0; i < requests; i++) begin
      r = $urandom_range(99);
      front = ($urandom_range(1) == 1);
      if (r < 55) begin
        for (int j = $urandom_range(5); j >= 0; j--)
          send_request(front ? KIND_FRONT : KIND_BACK,
                       $urandom_range(99) < 90 ? $urandom_range(span - 1) : $urandom_range(255),
                       j != 0 && $urandom_range(99) < 10);
      end else if (r < 62) begin
        send_request(front ? KIND_FRONT : KIND_BACK, $urandom_range(255), 1);
      end else if (r < 85) begin
        send_request(KIND_TAKE, $urandom_range(255), $urandom_range(1) == 1);
      end else begin
        send_request(KIND_MARK, $urandom_range(99) < 90 ? $urandom_range(span - 1)
                     : $urandom_range(255), $urandom_range(1) == 1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // reset limit of one chunk
    send_request(KIND_BACK, 0, 1);
    send_request(KIND_BACK, 1, 0);
    send_request(KIND_TAKE, 8'hff, 1);
    send_request(KIND_TAKE, 0, 0);
    drain_results();
    write_chunk_count(256);
    send_request(KIND_BACK, 255, 1);
    send_request(KIND_BACK, 3, 0);
    send_request(KIND_BACK, 3, 0);
    send_request(KIND_BACK, 7, 1);
    send_request(KIND_FRONT, 255, 1);
    send_request(KIND_FRONT, 7, 0);
    send_request(KIND_FRONT, 7, 0);
    send_request(KIND_BACK, 9, 0);
    send_request(KIND_FRONT, 2, 0);
    send_request(KIND_MARK, 255, 0);
    send_request(KIND_MARK, 255, 1);
    send_request(KIND_TAKE, 0, 0);
    send_request(KIND_MARK, 3, 0);
    send_request(KIND_MARK, 9, 0);
    send_request(KIND_TAKE, 0, 0);
    send_request(KIND_TAKE, 0, 0);
    send_request(KIND_FRONT, 3, 1);
    drain_results();
    write_chunk_count(0);
    send_request(KIND_BACK, 0, 1);
    send_request(KIND_MARK, 0, 0);
    drain_results();
    write_chunk_count(16);
    random_phase(150, 16);
    drain_results();
    write_chunk_count(300);
    calm_stretch = 1;
    random_phase(150, 256);
    calm_stretch = 0;
    drain_results();
    write_chunk_count(2);
    random_phase(60, 4);
    drain_results();
    write_chunk_count(40);
    random_phase(150, 48);
    drain_results();
    write_chunk_count(511);
    for (int i = 0; i < 256; i++) send_request(KIND_BACK, i, i == 0);
    for (int i = 0; i < 8; i++) send_request(KIND_FRONT, 255 - i, i == 0);
    random_phase(60, 256);
    drain_results();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
